// File: sv/xtc_pkg.sv
// ----------------------------------------------------------------------------
// xtc_pkg
// Shared constants, coefficient matrix and stage payload types for the
// XYZ to CMYK conversion pipeline.
// ----------------------------------------------------------------------------
package xtc_pkg;

  // Fixed-point format of the XYZ inputs
  localparam int FRAC_BITS = 16;
  localparam int IN_W      = 17;
  localparam int PCT_W     = 7;
  localparam int NCH       = 3;

  // Matrix coefficients are signed integers in units of 1e-6
  localparam int COEF_W = 23;
  localparam int PROD_W = IN_W + 1 + COEF_W;
  localparam int SUM_W  = PROD_W + 2;

  // 1.0 in sum units is 1e6 << FRAC_BITS, and 1e6 < 2^20
  localparam int INK_W = 20 + FRAC_BITS;
  localparam int NUM_W = INK_W + PCT_W;
  localparam int CMP_W = (SUM_W > INK_W + 1) ? SUM_W : INK_W + 1;

  localparam logic [INK_W-1:0] FULL = INK_W'(64'd1000000 << FRAC_BITS);
  localparam logic signed [CMP_W-1:0] FULL_CMP = CMP_W'(FULL);

  // Divider: one quotient bit per stage, three ink lanes plus black
  localparam int DIV_STAGES = PCT_W;
  localparam int LANES      = NCH + 1;
  localparam int BLK_LANE   = NCH;

  typedef logic signed [COEF_W-1:0] coef_t;

  localparam coef_t MAT [NCH][NCH] = '{
    '{coef_t'(3063219),  coef_t'(-1393326), coef_t'(-475801)},
    '{coef_t'(-969245),  coef_t'(1875968),  coef_t'(41555)},
    '{coef_t'(67872),    coef_t'(-228833),  coef_t'(1069251)}
  };

  // Clamped inks leaving the matrix section
  typedef struct packed {
    logic [NCH-1:0][INK_W-1:0] ink;
    logic                      oog;
  } ink_t;

  // Scaled numerators and shared denominator entering the divider
  typedef struct packed {
    logic [NCH-1:0][NUM_W-1:0] num;
    logic [NUM_W-1:0]          knum;
    logic [INK_W-1:0]          den;
    logic                      blk_full;
    logic                      oog;
  } div_in_t;

  // One divider stage
  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] rem;
    logic [LANES-1:0][PCT_W-1:0] quo;
    logic [INK_W-1:0]            den;
    logic                        blk_full;
    logic                        oog;
  } div_t;

  // Final result
  typedef struct packed {
    logic [PCT_W-1:0] cyan;
    logic [PCT_W-1:0] magenta;
    logic [PCT_W-1:0] yellow;
    logic [PCT_W-1:0] black;
    logic             oog;
  } result_t;

  // Multiply by 100 as shift-and-add: 64 + 32 + 4
  function automatic logic [NUM_W-1:0] times100(input logic [INK_W-1:0] val);
    logic [NUM_W-1:0] ext;
    ext = NUM_W'(val);
    return (ext << 6) + (ext << 5) + (ext << 2);
  endfunction

endpackage

// File: sv/xyz_to_cmyk_core.sv
// Throughput: one pixel per cycle while the output is accepted; every stage has
// its own valid bit and enable, so bubbles close up and input keeps flowing
// until every stage holds a pixel and the output is stalled.
// Each percentage comes from a seven-stage restoring divider, one bit per stage.
// Reset: rst_ni asynchronously clears all valid bits; payload registers keep
// their contents.
// ----------------------------------------------------------------------------
// xyz_to_cmyk_core
// CIE XYZ to CMYK converter: 3x3 matrix to linear RGB, clamp, black
// extraction and percentage division in a fully pipelined datapath.
// ----------------------------------------------------------------------------
module xyz_to_cmyk_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [xtc_pkg::IN_W-1:0]    x_value_i,
  input  logic [xtc_pkg::IN_W-1:0]    y_value_i,
  input  logic [xtc_pkg::IN_W-1:0]    z_value_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [xtc_pkg::PCT_W-1:0]   cyan_pct_o,
  output logic [xtc_pkg::PCT_W-1:0]   magenta_pct_o,
  output logic [xtc_pkg::PCT_W-1:0]   yellow_pct_o,
  output logic [xtc_pkg::PCT_W-1:0]   black_pct_o,
  output logic                        out_of_gamut_o
);
  import xtc_pkg::*;

  logic    mat_valid;
  logic    mat_ready;
  ink_t    mat_data;
  logic    ink_valid;
  logic    ink_ready;
  div_in_t ink_data;
  result_t res;

  // Matrix, clamp and ink conversion
  xtc_matrix u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .x_i         (x_value_i),
    .y_i         (y_value_i),
    .z_i         (z_value_i),
    .out_valid_o (mat_valid),
    .out_ready_i (mat_ready),
    .out_o       (mat_data)
  );

  // Black extraction and numerator scaling
  xtc_ink u_ink (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (mat_valid),
    .in_ready_o  (mat_ready),
    .in_i        (mat_data),
    .out_valid_o (ink_valid),
    .out_ready_i (ink_ready),
    .out_o       (ink_data)
  );

  // Percentage division
  xtc_divide u_divide (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ink_valid),
    .in_ready_o  (ink_ready),
    .in_i        (ink_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (res)
  );

  assign cyan_pct_o     = res.cyan;
  assign magenta_pct_o  = res.magenta;
  assign yellow_pct_o   = res.yellow;
  assign black_pct_o    = res.black;
  assign out_of_gamut_o = res.oog;

endmodule

// File: sv/xtc_matrix.sv
// ----------------------------------------------------------------------------
// xtc_matrix
// Three-stage XYZ to linear RGB matrix: multiply, sum, then clamp to [0,1]
// and convert each channel to ink as 1.0 minus the channel.
// ----------------------------------------------------------------------------
module xtc_matrix (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [xtc_pkg::IN_W-1:0]  x_i,
  input  logic [xtc_pkg::IN_W-1:0]  y_i,
  input  logic [xtc_pkg::IN_W-1:0]  z_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output xtc_pkg::ink_t             out_o
);
  import xtc_pkg::*;

  localparam int STAGES = 3;

  logic [STAGES-1:0] vld_q;
  logic [STAGES:0]   down;

  logic signed [IN_W:0]     xyz_s [NCH];
  logic signed [PROD_W-1:0] prod_d [NCH][NCH];
  logic signed [PROD_W-1:0] prod_q [NCH][NCH];
  logic signed [SUM_W-1:0]  sum_d [NCH];
  logic signed [SUM_W-1:0]  sum_q [NCH];
  ink_t                     ink_d;
  ink_t                     ink_q;

  // Stage enables: a stage advances when empty or when its successor moves
  always_comb begin
    down[STAGES] = out_ready_i;
    for (int s = STAGES - 1; s >= 0; s--) begin
      down[s] = !vld_q[s] || down[s+1];
    end
  end

  assign in_ready_o  = down[0];
  assign out_valid_o = vld_q[STAGES-1];
  assign out_o       = ink_q;

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (down[0]) vld_q[0] <= in_valid_i;
      if (down[1]) vld_q[1] <= vld_q[0];
      if (down[2]) vld_q[2] <= vld_q[1];
    end
  end

  // Stage 1: nine products
  assign xyz_s[0] = $signed({1'b0, x_i});
  assign xyz_s[1] = $signed({1'b0, y_i});
  assign xyz_s[2] = $signed({1'b0, z_i});

  always_comb begin
    for (int r = 0; r < NCH; r++) begin
      for (int c = 0; c < NCH; c++) begin
        prod_d[r][c] = PROD_W'(xyz_s[c]) * PROD_W'(MAT[r][c]);
      end
    end
  end

  // Stage 2: row sums
  always_comb begin
    for (int r = 0; r < NCH; r++) begin
      sum_d[r] = SUM_W'(prod_q[r][0]) + SUM_W'(prod_q[r][1]) + SUM_W'(prod_q[r][2]);
    end
  end

  // Stage 3: clamp each channel and flip to ink
  always_comb begin
    logic signed [CMP_W-1:0] ext;
    logic [INK_W-1:0]        ch;
    ink_d.oog = 1'b0;
    for (int r = 0; r < NCH; r++) begin
      ext = CMP_W'(sum_q[r]);
      if (ext[CMP_W-1]) begin
        ch        = '0;
        ink_d.oog = 1'b1;
      end else if (ext > FULL_CMP) begin
        ch        = FULL;
        ink_d.oog = 1'b1;
      end else begin
        ch = ext[INK_W-1:0];
      end
      ink_d.ink[r] = FULL - ch;
    end
  end

  // Hold payload on stall, load on advance
  always_ff @(posedge clk_i) begin
    if (down[0] && in_valid_i) prod_q <= prod_d;
    if (down[1] && vld_q[0])   sum_q  <= sum_d;
    if (down[2] && vld_q[1])   ink_q  <= ink_d;
  end

endmodule

// File: sv/xtc_ink.sv
// ----------------------------------------------------------------------------
// xtc_ink
// Two-stage black extraction: take black as the smallest ink, then form the
// scaled numerators and the shared denominator for the divider.
// ----------------------------------------------------------------------------
module xtc_ink (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  xtc_pkg::ink_t     in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output xtc_pkg::div_in_t  out_o
);
  import xtc_pkg::*;

  localparam int STAGES = 2;

  logic [STAGES-1:0] vld_q;
  logic [STAGES:0]   down;

  ink_t             ink_q;
  logic [INK_W-1:0] k_d;
  logic [INK_W-1:0] k_q;
  div_in_t          div_d;
  div_in_t          div_q;

  // Stage enables
  always_comb begin
    down[STAGES] = out_ready_i;
    for (int s = STAGES - 1; s >= 0; s--) begin
      down[s] = !vld_q[s] || down[s+1];
    end
  end

  assign in_ready_o  = down[0];
  assign out_valid_o = vld_q[STAGES-1];
  assign out_o       = div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (down[0]) vld_q[0] <= in_valid_i;
      if (down[1]) vld_q[1] <= vld_q[0];
    end
  end

  // Stage 1: black is the smallest ink
  always_comb begin
    k_d = in_i.ink[0];
    if (in_i.ink[1] < k_d) k_d = in_i.ink[1];
    if (in_i.ink[2] < k_d) k_d = in_i.ink[2];
  end

  // Stage 2: remove black and scale by 100
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      div_d.num[i] = times100(ink_q.ink[i] - k_q);
    end
    div_d.knum     = times100(k_q);
    div_d.den      = FULL - k_q;
    div_d.blk_full = (k_q == FULL);
    div_d.oog      = ink_q.oog;
  end

  always_ff @(posedge clk_i) begin
    if (down[0] && in_valid_i) begin
      ink_q <= in_i;
      k_q   <= k_d;
    end
    if (down[1] && vld_q[0]) div_q <= div_d;
  end

endmodule

// File: sv/xtc_divide.sv
// ----------------------------------------------------------------------------
// xtc_divide
// Restoring divider pipeline, one quotient bit per stage, for the three
// chromatic inks and black in parallel lanes; forms the final percentages.
// ----------------------------------------------------------------------------
module xtc_divide (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  xtc_pkg::div_in_t  in_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output xtc_pkg::result_t  out_o
);
  import xtc_pkg::*;

  logic [DIV_STAGES-1:0] vld_q;
  logic [DIV_STAGES:0]   down;

  div_t stage_q [DIV_STAGES];
  div_t src     [DIV_STAGES];
  div_t nxt     [DIV_STAGES];
  div_t init;

  // Stage enables
  always_comb begin
    down[DIV_STAGES] = out_ready_i;
    for (int s = DIV_STAGES - 1; s >= 0; s--) begin
      down[s] = !vld_q[s] || down[s+1];
    end
  end

  assign in_ready_o  = down[0];
  assign out_valid_o = vld_q[DIV_STAGES-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (down[0]) vld_q[0] <= in_valid_i;
      for (int s = 1; s < DIV_STAGES; s++) begin
        if (down[s]) vld_q[s] <= vld_q[s-1];
      end
    end
  end

  // Seed the remainders with the scaled numerators
  always_comb begin
    for (int l = 0; l < NCH; l++) begin
      init.rem[l] = in_i.num[l];
    end
    init.rem[BLK_LANE] = in_i.knum;
    init.quo           = '0;
    init.den           = in_i.den;
    init.blk_full      = in_i.blk_full;
    init.oog           = in_i.oog;
  end

  // Each stage tries the divisor shifted to its quotient bit
  always_comb begin
    logic [NUM_W-1:0] sh;
    logic             ge;
    src[0] = init;
    for (int s = 1; s < DIV_STAGES; s++) begin
      src[s] = stage_q[s-1];
    end
    for (int s = 0; s < DIV_STAGES; s++) begin
      nxt[s] = src[s];
      for (int l = 0; l < LANES; l++) begin
        if (l == BLK_LANE) begin
          sh = NUM_W'(FULL) << (DIV_STAGES - 1 - s);
        end else begin
          sh = NUM_W'(src[s].den) << (DIV_STAGES - 1 - s);
        end
        ge = (src[s].rem[l] >= sh);
        nxt[s].rem[l] = ge ? (src[s].rem[l] - sh) : src[s].rem[l];
        nxt[s].quo[l] = {src[s].quo[l][PCT_W-2:0], ge};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (down[0] && in_valid_i) stage_q[0] <= nxt[0];
    for (int s = 1; s < DIV_STAGES; s++) begin
      if (down[s] && vld_q[s-1]) stage_q[s] <= nxt[s];
    end
  end

  // Drop chromatic inks when black is full
  always_comb begin
    if (stage_q[DIV_STAGES-1].blk_full) begin
      out_o.cyan    = '0;
      out_o.magenta = '0;
      out_o.yellow  = '0;
    end else begin
      out_o.cyan    = stage_q[DIV_STAGES-1].quo[0];
      out_o.magenta = stage_q[DIV_STAGES-1].quo[1];
      out_o.yellow  = stage_q[DIV_STAGES-1].quo[2];
    end
    out_o.black = stage_q[DIV_STAGES-1].quo[BLK_LANE];
    out_o.oog   = stage_q[DIV_STAGES-1].oog;
  end

endmodule
